// ----- rtl/core/lcdb_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdb_pkg: shared types and constants for the LCD decimal encoder
// Seven-segment font, layout constants and the pipeline sideband type.
// ----------------------------------------------------------------------------
package lcdb_pkg;

  localparam int DigitCountDefault = 8;
  localparam int ValueWidth        = 32;
  localparam int PointWidth        = 3;
  localparam int ComCount          = 4;
  localparam int ComWidth          = 19;
  localparam int StepsPerStage     = 8;
  localparam int DabbleStages      = ValueWidth / StepsPerStage;

  // Point icons sit on COM3
  localparam int PointBitPos2 = 6;
  localparam int PointBitPos3 = 8;

  localparam logic [3:0] SegMinus = 4'd10;

  typedef logic [ComCount-1:0][ComWidth-1:0] lcdb_image_t;

  typedef struct packed {
    logic [PointWidth-1:0] point;
    logic                  neg;
  } lcdb_side_t;

  // Segments a..g in bits 0..6
  function automatic logic [6:0] seg7_font(logic [3:0] code);
    logic [6:0] pat;
    unique case (code)
      4'd0:     pat = 7'h3f;
      4'd1:     pat = 7'h06;
      4'd2:     pat = 7'h5b;
      4'd3:     pat = 7'h4f;
      4'd4:     pat = 7'h66;
      4'd5:     pat = 7'h6d;
      4'd6:     pat = 7'h7d;
      4'd7:     pat = 7'h07;
      4'd8:     pat = 7'h7f;
      4'd9:     pat = 7'h6f;
      SegMinus: pat = 7'h40;
      default:  pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/core/lcd_decimal_blanked_segments.sv -----
// ----------------------------------------------------------------------------
// lcd_decimal_blanked_segments: decimal number to 4-COM x 19-bit LCD image
// Pipeline: four converter slices of eight shift-and-add-3 steps each,
//   then the segment encoder, each with its own output register.
// Throughput: one item per cycle while the output is accepted; each stage has
//   its own ready, so bubbles close up while a result waits at the output register.
// Reset clears all stage valid bits; the data path is not reset.
// ----------------------------------------------------------------------------
module lcd_decimal_blanked_segments #(
  parameter int DIGIT_COUNT = lcdb_pkg::DigitCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] value, [34:32] point_position, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  // [0] negative
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [18:0] com0_segments, [37:19] com1_segments, [56:38] com2_segments,
  // [75:57] com3_segments, [79:76] zero
  output logic [79:0] m_axis_tdata
);
  import lcdb_pkg::*;

  localparam int BcdWidth = 4 * DIGIT_COUNT;

  logic                  valid_s [DabbleStages+1];
  logic                  ready_s [DabbleStages+1];
  logic [BcdWidth-1:0]   bcd_s   [DabbleStages+1];
  logic [ValueWidth-1:0] bin_s   [DabbleStages+1];
  lcdb_side_t            side_s  [DabbleStages+1];
  lcdb_image_t           image;

  assign valid_s[0]       = s_axis_tvalid;
  assign s_axis_tready    = ready_s[0];
  assign bcd_s[0]         = '0;
  assign bin_s[0]         = s_axis_tdata[ValueWidth-1:0];
  assign side_s[0].point  = s_axis_tdata[ValueWidth +: PointWidth];
  assign side_s[0].neg    = s_axis_tuser;

  for (genvar g = 0; g < DabbleStages; g++) begin : g_dabble
    lcdb_dabble_stage #(
      .DIGIT_COUNT(DIGIT_COUNT)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_s[g]),
      .ready_o(ready_s[g]),
      .bcd_i  (bcd_s[g]),
      .bin_i  (bin_s[g]),
      .side_i (side_s[g]),
      .valid_o(valid_s[g+1]),
      .ready_i(ready_s[g+1]),
      .bcd_o  (bcd_s[g+1]),
      .bin_o  (bin_s[g+1]),
      .side_o (side_s[g+1])
    );
  end

  lcdb_seg_encode #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_encode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(valid_s[DabbleStages]),
    .ready_o(ready_s[DabbleStages]),
    .bcd_i  (bcd_s[DabbleStages]),
    .side_i (side_s[DabbleStages]),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .image_o(image)
  );

  assign m_axis_tdata = {4'b0000, image};

  // The binary word is fully shifted out by the last converter slice
  logic unused_bin;
  assign unused_bin = |bin_s[DabbleStages];

  // An accepting sink lets every stage advance
  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output is accepted");

  // An item reaches the output within the pipeline depth when never stalled
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("item lost in pipeline");

  // Segment bits 0..2 are unused on every common line
  a_low_bits_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[2:0] == 3'b000) && (m_axis_tdata[21:19] == 3'b000)
      && (m_axis_tdata[40:38] == 3'b000) && (m_axis_tdata[59:57] == 3'b000))
    else $error("unused segment bit lit");

  // Units digit always shows something: segment a or b of digit 0 is lit
  a_units_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[3] || m_axis_tdata[22]))
    else $error("units digit blank");

endmodule

// ----- rtl/core/lcdb_dabble_stage.sv -----
// ----------------------------------------------------------------------------
// lcdb_dabble_stage: one registered slice of the binary to BCD converter
// Runs a fixed number of shift-and-add-3 steps, keeping only the low
// DIGIT_COUNT decimal digits (overflow out of the top digit is dropped).
// ----------------------------------------------------------------------------
module lcdb_dabble_stage #(
  parameter int DIGIT_COUNT = lcdb_pkg::DigitCountDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [4*DIGIT_COUNT-1:0]       bcd_i,
  input  logic [lcdb_pkg::ValueWidth-1:0] bin_i,
  input  lcdb_pkg::lcdb_side_t           side_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [4*DIGIT_COUNT-1:0]       bcd_o,
  output logic [lcdb_pkg::ValueWidth-1:0] bin_o,
  output lcdb_pkg::lcdb_side_t           side_o
);
  import lcdb_pkg::*;

  localparam int BcdWidth = 4 * DIGIT_COUNT;

  logic                  valid_q;
  logic [BcdWidth-1:0]   bcd_d, bcd_q;
  logic [ValueWidth-1:0] bin_d, bin_q;
  lcdb_side_t            side_q;
  logic                  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    bcd_d = bcd_i;
    bin_d = bin_i;
    for (int s = 0; s < StepsPerStage; s++) begin
      for (int d = 0; d < DIGIT_COUNT; d++) begin
        if (bcd_d[4*d +: 4] >= 4'd5) begin
          bcd_d[4*d +: 4] = 4'(bcd_d[4*d +: 4] + 4'd3);
        end
      end
      if (BcdWidth > 1) begin
        bcd_d = BcdWidth'({bcd_d, bin_d[ValueWidth-1]});
      end
      bin_d = {bin_d[ValueWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bcd_q  <= bcd_d;
      bin_q  <= bin_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign bcd_o   = bcd_q;
  assign bin_o   = bin_q;
  assign side_o  = side_q;

endmodule

// ----- rtl/core/lcdb_seg_encode.sv -----
// ----------------------------------------------------------------------------
// lcdb_seg_encode: blanking, point forcing, minus placement and segment map
// Registered output stage; it is also the output register of the block.
// ----------------------------------------------------------------------------
module lcdb_seg_encode #(
  parameter int DIGIT_COUNT = lcdb_pkg::DigitCountDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  logic [4*DIGIT_COUNT-1:0] bcd_i,
  input  lcdb_pkg::lcdb_side_t     side_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output lcdb_pkg::lcdb_image_t    image_o
);
  import lcdb_pkg::*;

  localparam logic [PointWidth-1:0] PointMax = PointWidth'(DIGIT_COUNT - 1);

  logic                  valid_q;
  lcdb_image_t           image_d, image_q;
  logic [PointWidth-1:0] point_c;
  logic [DIGIT_COUNT-1:0] shown;
  logic [DIGIT_COUNT-1:0] minus_at;
  logic                  load;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign point_c = (side_i.point > PointMax) ? PointMax : side_i.point;

  always_comb begin
    logic       nz_acc;
    logic [3:0] dig;
    logic [6:0] pat;
    nz_acc   = 1'b0;
    shown    = '0;
    minus_at = '0;
    image_d  = '0;
    // a digit shows if it is the units digit, a nonzero digit sits at or
    // above it, or it lies within the point position
    for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
      nz_acc   = nz_acc || (bcd_i[4*i +: 4] != 4'd0);
      shown[i] = (i == 0) || nz_acc || (PointWidth'(i) <= point_c);
    end
    for (int i = 1; i < DIGIT_COUNT; i++) begin
      minus_at[i] = side_i.neg && !shown[i] && shown[i-1];
    end
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      dig = bcd_i[4*i +: 4];
      if (shown[i]) begin
        pat = seg7_font(dig);
      end else if (minus_at[i]) begin
        pat = seg7_font(SegMinus);
      end else begin
        pat = 7'h00;
      end
      image_d[0][3 + 2*i] = pat[0];
      image_d[1][3 + 2*i] = pat[1];
      image_d[2][3 + 2*i] = pat[2];
      image_d[3][3 + 2*i] = pat[3];
      image_d[2][4 + 2*i] = pat[4];
      image_d[0][4 + 2*i] = pat[5];
      image_d[1][4 + 2*i] = pat[6];
    end
    if (point_c == PointWidth'(2)) begin
      image_d[3][PointBitPos2] = 1'b1;
    end else if (point_c == PointWidth'(3)) begin
      image_d[3][PointBitPos3] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      image_q <= image_d;
    end
  end

  assign valid_o = valid_q;
  assign image_o = image_q;

endmodule
